@@ hdl/sbc_pkg.sv @@
// Shared types, widths and helpers for the sphere/box contact pipeline.
package sbc_pkg;

  localparam int COORD_W   = 32;
  localparam int MAG_W     = COORD_W - 1;
  localparam int AXIS_FRAC = 14;
  localparam int AXIS_W    = AXIS_FRAC + 2;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int ROOT_W    = COORD_W;
  localparam int QUO_W     = AXIS_FRAC + 1;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int NUM_W     = MAG_W + QUO_W + 1;
  localparam int DOT_W     = MAG_W + QUO_W + 2;
  localparam int DOTQ_W    = DOT_W - AXIS_FRAC;
  localparam int SAT_IN_W  = COORD_W + 4;

  typedef struct packed {
    logic signed [COORD_W-1:0] sphere_x;
    logic signed [COORD_W-1:0] sphere_y;
    logic signed [COORD_W-1:0] sphere_z;
    logic        [MAG_W-1:0]   sphere_radius;
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic signed [COORD_W-1:0] box_z;
    logic        [MAG_W-1:0]   half_x;
    logic        [MAG_W-1:0]   half_y;
    logic        [MAG_W-1:0]   half_z;
  } pair_t;

  typedef struct packed {
    logic                      touching;
    logic signed [AXIS_W-1:0]  axis_x;
    logic signed [AXIS_W-1:0]  axis_y;
    logic signed [AXIS_W-1:0]  axis_z;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] depth;
  } hit_t;

  localparam logic signed [SAT_IN_W-1:0] SAT_HI =
      SAT_IN_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_HI - SAT_IN_W'(1);

  function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [SAT_IN_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_HI) r = COORD_W'(SAT_HI);
    else if (v < SAT_LO) r = COORD_W'(SAT_LO);
    else r = COORD_W'(v);
    return r;
  endfunction

endpackage

@@ hdl/sbc_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, with side-band tag.
module sbc_isqrt #(
  parameter int TAG_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vin,
  input  logic [sbc_pkg::SQ_W-1:0]   x_in,
  input  logic [TAG_W-1:0]           tag_in,
  output logic                       vout,
  output logic [sbc_pkg::ROOT_W-1:0] root,
  output logic [TAG_W-1:0]           tag_out
);
  import sbc_pkg::*;

  localparam int STEPS = ROOT_W;

  logic             vld [0:STEPS];
  logic [SQ_W-1:0]  rem [0:STEPS];
  logic [SQ_W-1:0]  res [0:STEPS];
  logic [TAG_W-1:0] tag [0:STEPS];

  assign vld[0] = vin;
  assign rem[0] = x_in;
  assign res[0] = '0;
  assign tag[0] = tag_in;

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (STEPS - 1 - j));
    logic [SQ_W-1:0] trial;
    logic            take;

    assign trial = res[j] + BIT;
    assign take  = rem[j] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
      if (en) begin
        rem[j+1] <= take ? rem[j] - trial : rem[j];
        res[j+1] <= take ? (res[j] >> 1) + BIT : res[j] >> 1;
        tag[j+1] <= tag[j];
      end
    end
  end

  assign vout    = vld[STEPS];
  assign root    = res[STEPS][ROOT_W-1:0];
  assign tag_out = tag[STEPS];

endmodule

@@ hdl/sbc_div.sv @@
// Three-lane pipelined rounding divider: q = (ad * 2^(F+1) + dist) / (2 * dist).
module sbc_div #(
  parameter int TAG_W = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             vin,
  input  logic [sbc_pkg::ROOT_W-1:0]       dist_in,
  input  logic [2:0][sbc_pkg::MAG_W-1:0]   ad_in,
  input  logic [TAG_W-1:0]                 tag_in,
  output logic                             vout,
  output logic [2:0][sbc_pkg::QUO_W-1:0]   quo,
  output logic [TAG_W-1:0]                 tag_out
);
  import sbc_pkg::*;

  logic             vld [0:QUO_W];
  logic [DEN_W-1:0] den [0:QUO_W];
  logic [NUM_W-1:0] rem [0:QUO_W][3];
  logic [QUO_W-1:0] q   [0:QUO_W][3];
  logic [TAG_W-1:0] tag [0:QUO_W];

  logic [ROOT_W-1:0] dist_nz;

  assign dist_nz = (dist_in == '0) ? ROOT_W'(1) : dist_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= vin;
    end
    if (en) begin
      den[0] <= {dist_nz, 1'b0};
      tag[0] <= tag_in;
      for (int l = 0; l < 3; l++) begin
        rem[0][l] <= (NUM_W'(ad_in[l]) << QUO_W) + NUM_W'(dist_nz);
        q[0][l]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    localparam int SH = QUO_W - 1 - j;
    logic [NUM_W-1:0] sub;
    logic [2:0]       take;

    assign sub = NUM_W'(den[j]) << SH;
    always_comb begin
      for (int l = 0; l < 3; l++) take[l] = rem[j][l] >= sub;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
      if (en) begin
        den[j+1] <= den[j];
        tag[j+1] <= tag[j];
        for (int l = 0; l < 3; l++) begin
          rem[j+1][l] <= take[l] ? rem[j][l] - sub : rem[j][l];
          q[j+1][l]   <= {q[j][l][QUO_W-2:0], take[l]};
        end
      end
    end
  end

  assign vout    = vld[QUO_W];
  assign tag_out = tag[QUO_W];
  always_comb begin
    for (int l = 0; l < 3; l++) quo[l] = q[QUO_W][l];
  end

endmodule

@@ hdl/sphere_box_contact_top.sv @@
// Sphere versus axis-aligned box contact: clamp, distance test, axis, depth.
// Pipeline from accepted pair beat to hit beat: 4 front stages,
// 32 square-root stages, 16 divider stages, 3 back stages.
// Throughput: one pair per cycle; the whole pipeline holds while a hit is stalled.
// Reset: synchronous, clears every stage valid bit; payload registers are not reset.
module sphere_box_contact_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           pair_valid,
  output logic           pair_stall,
  input  sbc_pkg::pair_t pair,
  output logic           hit_valid,
  input  logic           hit_stall,
  output sbc_pkg::hit_t  hit
);
  import sbc_pkg::*;

  typedef struct packed {
    logic                           touch;
    logic                           inbox;
    logic [2:0][AXIS_W-1:0]         iaxis;
    logic [2:0][COORD_W-1:0]        point;
    logic [MAG_W-1:0]               r;
    logic [2:0][MAG_W-1:0]          ad;
    logic [2:0]                     neg;
  } carry_t;

  localparam int CW = $bits(carry_t);

  logic en;
  assign en         = !(hit_valid && hit_stall);
  assign pair_stall = !en;

  // stage 1: relative center
  logic signed [COORD_W-1:0] sp [3];
  logic signed [COORD_W-1:0] bp [3];
  logic        [MAG_W-1:0]   hp [3];
  assign sp = '{pair.sphere_x, pair.sphere_y, pair.sphere_z};
  assign bp = '{pair.box_x, pair.box_y, pair.box_z};
  assign hp = '{pair.half_x, pair.half_y, pair.half_z};

  logic                      v1;
  logic signed [COORD_W:0]   rel1 [3];
  logic signed [COORD_W-1:0] bc1  [3];
  logic        [MAG_W-1:0]   h1   [3];
  logic        [MAG_W-1:0]   r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pair_valid;
    end
    if (en) begin
      r1 <= pair.sphere_radius;
      for (int i = 0; i < 3; i++) begin
        rel1[i] <= (COORD_W+1)'(sp[i]) - (COORD_W+1)'(bp[i]);
        bc1[i]  <= bp[i];
        h1[i]   <= hp[i];
      end
    end
  end

  // stage 2: clamp, difference, world point
  logic signed [COORD_W:0]   clo  [3];
  logic signed [COORD_W+1:0] dif  [3];
  logic        [COORD_W+1:0] adw  [3];
  logic        [COORD_W:0]   rabs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [COORD_W:0] hs;
      hs = signed'({2'b00, h1[i]});
      if (rel1[i] > hs) clo[i] = hs;
      else if (rel1[i] < -hs) clo[i] = -hs;
      else clo[i] = rel1[i];
      dif[i]  = (COORD_W+2)'(rel1[i]) - (COORD_W+2)'(clo[i]);
      adw[i]  = dif[i][COORD_W+1] ? unsigned'(-dif[i]) : unsigned'(dif[i]);
      rabs[i] = rel1[i][COORD_W] ? unsigned'(-rel1[i]) : unsigned'(rel1[i]);
    end
  end

  logic                 v2;
  logic [2:0]           far2, in2, neg2, cneg2;
  logic [MAG_W-1:0]     ad2   [3];
  logic [COORD_W-1:0]   room2 [3];
  logic [COORD_W-1:0]   pt2   [3];
  logic [MAG_W-1:0]     r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      r2 <= r1;
      for (int i = 0; i < 3; i++) begin
        far2[i]  <= adw[i] > (COORD_W+2)'(r1);
        in2[i]   <= adw[i] == '0;
        neg2[i]  <= dif[i][COORD_W+1];
        cneg2[i] <= clo[i][COORD_W];
        ad2[i]   <= adw[i][MAG_W-1:0];
        room2[i] <= COORD_W'((COORD_W+1)'(h1[i]) - rabs[i]);
        pt2[i]   <= sat_coord(SAT_IN_W'(clo[i]) + SAT_IN_W'(bc1[i]));
      end
    end
  end

  // stage 3: squares, inside-case axis
  logic [1:0] kmin;
  always_comb begin
    logic [COORD_W-1:0] best;
    kmin = 2'd0;
    best = room2[0];
    if (room2[1] < best) begin
      kmin = 2'd1;
      best = room2[1];
    end
    if (room2[2] < best) kmin = 2'd2;
  end

  localparam logic signed [AXIS_W-1:0] AXIS_ONE = AXIS_W'(1) << AXIS_FRAC;

  logic                       v3, far3, in3;
  logic [SQ_W-3:0]            sq3 [3];
  logic [SQ_W-3:0]            rr3;
  logic [2:0][AXIS_W-1:0]     iax3;
  logic [2:0][COORD_W-1:0]    pt3;
  logic [2:0][MAG_W-1:0]      ad3;
  logic [2:0]                 neg3;
  logic [MAG_W-1:0]           r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      far3 <= |far2;
      in3  <= &in2;
      rr3  <= r2 * r2;
      r3   <= r2;
      neg3 <= neg2;
      for (int i = 0; i < 3; i++) begin
        sq3[i]  <= ad2[i] * ad2[i];
        ad3[i]  <= ad2[i];
        pt3[i]  <= pt2[i];
        iax3[i] <= (kmin == 2'(i)) ? (cneg2[i] ? -AXIS_ONE : AXIS_ONE) : '0;
      end
    end
  end

  // stage 4: squared distance and contact test
  logic [SQ_W-1:0] dsq;
  assign dsq = SQ_W'(sq3[0]) + SQ_W'(sq3[1]) + SQ_W'(sq3[2]);

  logic            v4;
  logic [SQ_W-1:0] dsq4;
  carry_t          c4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      dsq4      <= dsq;
      c4.touch  <= !far3 && (dsq < SQ_W'(rr3));
      c4.inbox  <= in3;
      c4.iaxis  <= iax3;
      c4.point  <= pt3;
      c4.r      <= r3;
      c4.ad     <= ad3;
      c4.neg    <= neg3;
    end
  end

  // distance and axis division
  logic              vs;
  logic [ROOT_W-1:0] root_len;
  logic [CW-1:0]     ts;
  carry_t            cs;

  sbc_isqrt #(.TAG_W(CW)) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vin     (v4),
    .x_in    (dsq4),
    .tag_in  (c4),
    .vout    (vs),
    .root    (root_len),
    .tag_out (ts)
  );
  assign cs = carry_t'(ts);

  logic                   vd;
  logic [2:0][QUO_W-1:0]  quo;
  logic [CW-1:0]          td;
  carry_t                 cd;

  sbc_div #(.TAG_W(CW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vin     (vs),
    .dist_in (root_len),
    .ad_in   (cs.ad),
    .tag_in  (ts),
    .vout    (vd),
    .quo     (quo),
    .tag_out (td)
  );
  assign cd = carry_t'(td);

  // back stages: dot product, depth, output
  logic                       vm;
  logic [DOT_W-3:0]           prod [3];
  logic [2:0][QUO_W-1:0]      qm;
  carry_t                     cm;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= vd;
    end
    if (en) begin
      cm <= cd;
      qm <= quo;
      for (int i = 0; i < 3; i++) prod[i] <= quo[i] * cd.ad[i];
    end
  end

  localparam logic [DOT_W-1:0] DOT_HALF = DOT_W'(1) << (AXIS_FRAC - 1);

  logic [DOT_W-1:0] dot;
  assign dot = DOT_W'(prod[0]) + DOT_W'(prod[1]) + DOT_W'(prod[2]) + DOT_HALF;

  logic                   vq;
  logic [DOTQ_W-1:0]      dotq;
  logic [2:0][QUO_W-1:0]  qq;
  carry_t                 cq;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else if (en) begin
      vq <= vm;
    end
    if (en) begin
      dotq <= dot[DOT_W-1:AXIS_FRAC];
      qq   <= qm;
      cq   <= cm;
    end
  end

  hit_t res;
  always_comb begin
    logic signed [SAT_IN_W-1:0] dw;
    logic signed [AXIS_W-1:0]   ax [3];
    logic signed [COORD_W-1:0]  dep;
    dw = SAT_IN_W'(cq.r) - SAT_IN_W'(dotq);
    for (int i = 0; i < 3; i++) begin
      if (cq.inbox) ax[i] = cq.iaxis[i];
      else if (cq.neg[i]) ax[i] = -AXIS_W'(qq[i]);
      else ax[i] = AXIS_W'(qq[i]);
    end
    dep = cq.inbox ? COORD_W'(cq.r) : sat_coord(dw);
    res = '0;
    if (cq.touch) begin
      res.touching = 1'b1;
      res.axis_x   = ax[0];
      res.axis_y   = ax[1];
      res.axis_z   = ax[2];
      res.point_x  = cq.point[0];
      res.point_y  = cq.point[1];
      res.point_z  = cq.point[2];
      res.depth    = dep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (en) begin
      hit_valid <= vq;
    end
    if (en) begin
      hit <= res;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
      hit_valid && !hit.touching |-> hit.depth == '0 && hit.axis_x == '0
        && hit.axis_y == '0 && hit.axis_z == '0 && hit.point_x == '0)
    else $error("non-contact beat carries nonzero fields");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
      hit_valid && hit.touching |-> hit.axis_x <= AXIS_ONE && hit.axis_x >= -AXIS_ONE
        && hit.axis_y <= AXIS_ONE && hit.axis_y >= -AXIS_ONE
        && hit.axis_z <= AXIS_ONE && hit.axis_z >= -AXIS_ONE)
    else $error("axis component out of unit range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      hit_valid && hit_stall |-> pair_stall ##1 (hit_valid && $stable(hit)))
    else $error("stalled hit beat lost or pipeline advanced");

  a_reset: assert property (@(posedge clk) rst |=> !hit_valid)
    else $error("hit valid after reset");

endmodule

@@ test/tb_sphere_box_contact_top.sv @@
// Testbench for the sphere versus axis-aligned box contact pipeline.
module tb_sphere_box_contact_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sbc_pkg::*;

  localparam int LATENCY = 55;
  localparam int NUM_RANDOM = 1630;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pair_valid = 1'b0;
  logic pair_stall;
  pair_t pair = '0;
  logic hit_valid;
  logic hit_stall = 1'b0;
  hit_t hit;

  pair_t pending_pairs[$];
  hit_t expected_hits[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  bit hold_req = 1'b0;
  bit hold_armed = 1'b0;
  bit stim_done = 1'b0;

  sphere_box_contact_top dut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
    .hit_valid(hit_valid), .hit_stall(hit_stall), .hit(hit)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic hit_t contact_of(pair_t p);
    hit_t h;
    longint s[3], bc[3], clo[3], rel, d, depth, ax[3];
    longint unsigned hx[3], ad[3], rabs[3], r, dsq, best, room, dist_v, q, dot, dotq;
    bit neg[3];
    bit far, in_box;
    int k;
    h = '0;
    s[0] = p.sphere_x; s[1] = p.sphere_y; s[2] = p.sphere_z;
    bc[0] = p.box_x; bc[1] = p.box_y; bc[2] = p.box_z;
    hx[0] = p.half_x; hx[1] = p.half_y; hx[2] = p.half_z;
    r = p.sphere_radius;
    far = 0; in_box = 1; dsq = 0;
    for (int i = 0; i < 3; i++) begin
      rel = s[i] - bc[i];
      clo[i] = rel;
      if (rel > longint'(hx[i])) clo[i] = hx[i];
      if (rel < -longint'(hx[i])) clo[i] = -longint'(hx[i]);
      d = rel - clo[i];
      neg[i] = d < 0;
      ad[i] = neg[i] ? -d : d;
      rabs[i] = rel < 0 ? -rel : rel;
      if (ad[i] != 0) in_box = 0;
      if (ad[i] > r) far = 1;
      ax[i] = 0;
    end
    if (far) return h;
    for (int i = 0; i < 3; i++) dsq += ad[i] * ad[i];
    if (!(dsq < r * r)) return h;
    if (in_box) begin
      k = 0;
      best = hx[0] - rabs[0];
      for (int i = 1; i < 3; i++) begin
        room = hx[i] - rabs[i];
        if (room < best) begin
          best = room;
          k = i;
        end
      end
      ax[k] = clo[k] < 0 ? -(64'sd1 << AXIS_FRAC) : (64'sd1 << AXIS_FRAC);
      depth = r;
    end else begin
      dist_v = root_floor(dsq);
      if (dist_v == 0) dist_v = 1;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        q = ((ad[i] << (AXIS_FRAC + 1)) + dist_v) / (dist_v << 1);
        dot += q * ad[i];
        ax[i] = neg[i] ? -longint'(q) : longint'(q);
      end
      dotq = (dot + (64'd1 << (AXIS_FRAC - 1))) >> AXIS_FRAC;
      depth = longint'(r) - longint'(dotq & 64'h3FFF_FFFF_FFFF_FFFF);
    end
    h.touching = 1'b1;
    h.axis_x = ax[0][AXIS_W-1:0];
    h.axis_y = ax[1][AXIS_W-1:0];
    h.axis_z = ax[2][AXIS_W-1:0];
    h.point_x = clip_coord(clo[0] + bc[0]);
    h.point_y = clip_coord(clo[1] + bc[1]);
    h.point_z = clip_coord(clo[2] + bc[2]);
    h.depth = clip_coord(depth);
    return h;
  endfunction

  function automatic logic [31:0] rand_coord(int spread);
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom;
      default: return 32'($signed(-spread + $urandom_range(0, 2 * spread)));
    endcase
  endfunction

  function automatic logic [MAG_W-1:0] rand_mag(int spread);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return MAG_W'($urandom);
      default: return MAG_W'($urandom_range(0, spread));
    endcase
  endfunction

  // Mostly pairs close enough to touch, with wide-range noise mixed in.
  function automatic pair_t rand_pair();
    pair_t p;
    int spread;
    logic [31:0] off;
    logic [319:0] raw;
    spread = 1 << $urandom_range(4, 22);
    p.box_x = $urandom; p.box_y = $urandom; p.box_z = $urandom;
    if ($urandom_range(0, 4) == 0) begin
      p.box_x = rand_coord(spread); p.box_y = rand_coord(spread); p.box_z = rand_coord(spread);
    end
    p.half_x = rand_mag(spread); p.half_y = rand_mag(spread); p.half_z = rand_mag(spread);
    p.sphere_radius = rand_mag(4 * spread);
    off = rand_coord(2 * spread); p.sphere_x = p.box_x + off;
    off = rand_coord(2 * spread); p.sphere_y = p.box_y + off;
    off = rand_coord(2 * spread); p.sphere_z = p.box_z + off;
    if ($urandom_range(0, 9) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
      p = raw[$bits(pair_t)-1:0];
    end
    return p;
  endfunction

  function automatic pair_t mk(int sx, int sy, int sz, int r, int bx, int by, int bz,
                               int hx, int hy, int hz);
    pair_t p;
    p.sphere_x = sx; p.sphere_y = sy; p.sphere_z = sz;
    p.sphere_radius = MAG_W'(r);
    p.box_x = bx; p.box_y = by; p.box_z = bz;
    p.half_x = MAG_W'(hx); p.half_y = MAG_W'(hy); p.half_z = MAG_W'(hz);
    return p;
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (pending_pairs.size() != 0 || pair_valid || expected_hits.size() != 0)
      @(negedge clk);
  endtask

  // Sender
  always @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (!pair_valid || !pair_stall) begin
      if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        pair <= pending_pairs.pop_front();
        pair_valid <= 1'b1;
      end else begin
        pair_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pair_valid && !pair_stall) expected_hits.push_back(contact_of(pair));
  end

  // Receiver hold-off counter
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 0;
      hold_armed <= 1'b1;
    end else if (hold_req && hold_armed) begin
      hold_off <= 300;
      hold_armed <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Receiver and checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      hit_stall <= 1'b0;
    end else begin
      if (hold_off > 0) begin
        hit_stall <= 1'b1;
      end else begin
        hit_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
      if (hit_valid && !hit_stall) begin
        if (expected_hits.size() == 0) begin
          errors++;
          $display("%0t: unexpected hit beat %p", $time, hit);
        end else if (hit !== expected_hits[0]) begin
          errors++;
          $display("%0t: hit mismatch expected %p actual %p", $time, expected_hits[0], hit);
          void'(expected_hits.pop_front());
        end else begin
          void'(expected_hits.pop_front());
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(mk(0, 0, 0, 65536, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(mk(10, -5, 3, 65536, 0, 0, 0, 100, 100, 100));
    pending_pairs.push_back(mk(-90, 5, 3, 65536, 0, 0, 0, 100, 100, 100));
    pending_pairs.push_back(mk(0, 0, 0, 65536, 0, 0, 0, 100, 100, 100));
    pending_pairs.push_back(mk(0, 0, -99, 65536, 0, 0, 0, 100, 100, 100));
    pending_pairs.push_back(mk(200000, 0, 0, 65536, 0, 0, 0, 150000, 65536, 65536));
    pending_pairs.push_back(mk(-180000, 170000, 0, 65536, 0, 0, 0, 150000, 150000, 65536));
    pending_pairs.push_back(mk(200000, 0, 0, 30000, 0, 0, 0, 150000, 65536, 65536));
    pending_pairs.push_back(mk(200000, 0, 0, 50000, 0, 0, 0, 150000, 65536, 65536));
    pending_pairs.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_pairs.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_pairs.push_back(mk(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_0000, 0, 0,
                               32'h7FFF_FFFF, 0, 0));
    pending_pairs.push_back(mk(32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF,
                               0, 0, 0, 32'h7FFF_0000, 32'h7FFF_0000, 0));
    pending_pairs.push_back(mk(1, 1, 1, 2, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(mk(-1, -1, -1, 2, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(mk(65536, 65536, 65536, 200000, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(mk(-1, 0, 0, 7, 0, 0, 0, 0, 0, 0));
    send_idle_pct = 31; recv_idle_pct = 72;
    for (int i = 0; i < NUM_RANDOM / 3; i++) pending_pairs.push_back(rand_pair());
    wait_drained();
    // long receiver hold-off while the sender keeps offering pairs
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 150; i++) pending_pairs.push_back(rand_pair());
    hold_req = 1'b1;
    wait_drained();
    send_idle_pct = 72; recv_idle_pct = 31;
    for (int i = 0; i < NUM_RANDOM / 3 - 150; i++) pending_pairs.push_back(rand_pair());
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < NUM_RANDOM / 3; i++) pending_pairs.push_back(rand_pair());
    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
